// ----- sv/sorted_priority_queue_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

// ----- sv/spq_pkg.sv -----
package spq_pkg;

    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 8;
    localparam int DEPTH_DEFAULT = 128;

    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    // Operation codes on s_func
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } cell_ctrl_t;

endpackage

// ----- sv/spq_cell.sv -----
module spq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 8
) (
    input  logic                             aclk,
    input  spq_pkg::cell_ctrl_t              ctrl,
    input  logic [CW-1:0]                    count,
    input  logic                             left_gt,
    input  logic signed [spq_pkg::DATA_W-1:0] left_value,
    input  logic signed [spq_pkg::DATA_W-1:0] left_prio,
    input  logic signed [spq_pkg::DATA_W-1:0] right_value,
    input  logic signed [spq_pkg::DATA_W-1:0] right_prio,
    output logic                             gt,
    output logic signed [spq_pkg::DATA_W-1:0] value,
    output logic signed [spq_pkg::DATA_W-1:0] prio
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic signed [DATA_W-1:0] prio_reg, prio_next;
    logic                     occupied;
    logic                     at_tail;
    logic                     insert_here;

    // Occupancy of this slot follows from the entry count
    assign occupied = CW'(IDX) < count;
    assign at_tail  = CW'(IDX) == count;

    // New entry goes behind every stored entry of equal or smaller priority
    assign gt          = occupied && (ctrl.prio < prio_reg);
    assign insert_here = !left_gt && (gt || at_tail);

    // Hold, shift right, insert, or shift left toward the head
    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.enq) begin
            if (left_gt) begin
                value_next = left_value;
                prio_next  = left_prio;
            end
            if (insert_here) begin
                value_next = ctrl.value;
                prio_next  = ctrl.prio;
            end
        end else if (ctrl.deq) begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

// ----- sv/sorted_priority_queue_top.sv -----
// Sorted priority queue of DEPTH entries built as a row of cells, cell 0 holding the
// entry that leaves next. One operation (enqueue or dequeue) is taken per clock cycle
// while s_ready is high; its result is registered in the cycle after the transfer, and
// every cell compares the incoming priority in parallel and shifts one place toward or
// away from the head, so the cell compare and shift sets the single-cycle rate. Equal
// priorities leave in arrival order. An enqueue into a full queue is dropped with
// status full, a dequeue on an empty queue returns -1 with status empty, and every
// result reports the occupancy after the operation. A new operation is taken while a
// result waits as long as that result is taken in the same cycle.
module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic signed [spq_pkg::DATA_W-1:0] s_item_value,
    input  logic signed [spq_pkg::DATA_W-1:0] s_item_priority,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [spq_pkg::DATA_W-1:0] m_out_value,
    output logic [spq_pkg::STATUS_W-1:0]      m_status,
    output logic [spq_pkg::OCC_W-1:0]         m_occupancy
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]            count_reg, count_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    status_t                  status_reg, status_next;
    logic [OCC_W-1:0]         occ_reg, occ_next;

    logic                     xfer_in;
    logic                     is_full;
    logic                     is_empty;
    cell_ctrl_t               ctrl;
    logic [CW+OCC_W-1:0]      occ_ext;

    logic                     gt_w    [DEPTH];
    logic signed [DATA_W-1:0] value_w [DEPTH];
    logic signed [DATA_W-1:0] prio_w  [DEPTH];

    assign s_ready  = !m_valid_reg || m_ready;
    assign xfer_in  = s_valid && s_ready;
    assign is_full  = count_reg == CW'(DEPTH);
    assign is_empty = count_reg == '0;

    // Broadcast the operation to the cells
    always_comb begin
        ctrl.enq   = xfer_in && (s_func == FUNC_ENQ) && !is_full;
        ctrl.deq   = xfer_in && (s_func == FUNC_DEQ) && !is_empty;
        ctrl.value = s_item_value;
        ctrl.prio  = s_item_priority;
    end

    // Cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                     left_gt;
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] left_prio;
        logic signed [DATA_W-1:0] right_value;
        logic signed [DATA_W-1:0] right_prio;

        if (i == 0) begin : g_head
            assign left_gt    = 1'b0;
            assign left_value = '0;
            assign left_prio  = '0;
        end else begin : g_mid
            assign left_gt    = gt_w[i-1];
            assign left_value = value_w[i-1];
            assign left_prio  = prio_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_value = value_w[i];
            assign right_prio  = prio_w[i];
        end else begin : g_inner
            assign right_value = value_w[i+1];
            assign right_prio  = prio_w[i+1];
        end

        spq_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_gt     (left_gt),
            .left_value  (left_value),
            .left_prio   (left_prio),
            .right_value (right_value),
            .right_prio  (right_prio),
            .gt          (gt_w[i]),
            .value       (value_w[i]),
            .prio        (prio_w[i])
        );
    end

    // Entry count and result register
    always_comb begin
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        if (ctrl.enq) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.deq) begin
            count_next = count_reg - CW'(1);
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (xfer_in) begin
            m_valid_next = 1'b1;
            if (s_func == FUNC_ENQ) begin
                out_value_next = '0;
                status_next    = is_full ? ST_FULL : ST_OK;
            end else begin
                out_value_next = is_empty ? EMPTY_VALUE : value_w[0];
                status_next    = is_empty ? ST_EMPTY : ST_OK;
            end
        end
    end

    assign occ_ext  = {{OCC_W{1'b0}}, count_next};
    assign occ_next = xfer_in ? occ_ext[OCC_W-1:0] : occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        occ_reg       <= occ_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = out_value_reg;
    assign m_status    = status_reg;
    assign m_occupancy = occ_reg;

endmodule

// ----- sv/spq_checker.sv -----
`include "sorted_priority_queue_top_defines.svh"

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [spq_pkg::DATA_W-1:0] m_out_value,
    input logic [spq_pkg::STATUS_W-1:0]      m_status,
    input logic [spq_pkg::OCC_W-1:0]         m_occupancy
);
    import spq_pkg::*;

    // Stalled result holds
    `SPQ_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_out_value) && $stable(m_status) && $stable(m_occupancy))

    // Every input transfer yields a result in the next cycle
    `SPQ_ASSERT_NEXT(a_result, s_valid && s_ready, m_valid)

    // Dropped enqueue only on a full queue
    `SPQ_ASSERT_NOW(a_full, m_valid && (m_status == ST_FULL), (m_occupancy == OCC_W'(DEPTH)) && (m_out_value == '0))

    // Empty dequeue leaves nothing stored and returns the empty marker
    `SPQ_ASSERT_NOW(a_empty, m_valid && (m_status == ST_EMPTY), (m_occupancy == '0) && (m_out_value == EMPTY_VALUE))

endmodule

bind sorted_priority_queue_top spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
